FILE: hdl/rcm_pkg.sv
// Shared constants, types and register indexes of the block RMS current meter.
package rcm_pkg;

  // Sample width default and the fixed widths of the registers and the reading.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SUM_GUARD_BITS  = 6;
  localparam int FRAC_BITS       = 16;
  localparam int BLEN_BITS       = 8;
  localparam int GAIN_BITS       = 17;
  localparam int READING_BITS    = 16;
  localparam int SCALE_SHIFT     = 24;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_LENGTH = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_GAIN  = 4'd1;

  // Reset values of the registers: 50 samples per reading and a gain of
  // 0.0125 * 100 / sqrt(2) in Q16.
  localparam logic [BLEN_BITS-1:0] BLOCK_LENGTH_RESET = 8'd50;
  localparam logic [GAIN_BITS-1:0] OUTPUT_GAIN_RESET  = 17'd57926;

  // Status that each serial unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ENDTEST,
    ST_DIVIDE,
    ST_ROOT,
    ST_SCALE,
    ST_WRITE
  } state_t;

endpackage

FILE: hdl/rcm_serial_mul.sv
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
module rcm_serial_mul #(
  parameter int A_BITS = 16,
  parameter int B_BITS = 16,
  parameter int P_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [A_BITS-1:0]   a,
  input  logic [B_BITS-1:0]   b,
  output rcm_pkg::unit_stat_t stat,
  output logic [P_BITS-1:0]   product
);
  import rcm_pkg::*;

  logic              busy;
  logic              done;
  logic [P_BITS-1:0] mcand;
  logic [B_BITS-1:0] mplier;

  // Control: the unit stops once no set multiplier bit is left.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (mplier[B_BITS-1:1] == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set multiplier bit.
  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      mcand   <= P_BITS'(a);
      mplier  <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mcand  <= {mcand[P_BITS-2:0], 1'b0};
      mplier <= mplier >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/rcm_div.sv
// Restoring divider that produces one quotient bit per cycle.
module rcm_div #(
  parameter int NUM_BITS = 54,
  parameter int DEN_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output rcm_pkg::unit_stat_t stat,
  output logic [NUM_BITS-1:0] quotient
);
  import rcm_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] steps;
  logic [NUM_BITS-1:0] work;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den_hold;
  logic [DEN_BITS:0]   rem_shift;
  logic [DEN_BITS:0]   rem_diff;
  logic                fits;

  // One step: bring down the next dividend bit and try a subtraction.
  assign rem_shift = {rem, work[NUM_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, den_hold};
  assign fits      = (rem_shift >= {1'b0, den_hold});

  // Control: a fixed number of steps, one per quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out at the top while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      work     <= num;
      rem      <= '0;
      den_hold <= den;
    end else if (busy) begin
      work <= {work[NUM_BITS-2:0], fits};
      rem  <= fits ? rem_diff[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
    end
  end

  assign quotient  = work;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/rcm_sqrt.sv
// Digit-by-digit floor square root that produces one root bit per cycle.
module rcm_sqrt #(
  parameter int RAD_BITS = 54
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RAD_BITS-1:0]   radicand,
  output rcm_pkg::unit_stat_t   stat,
  output logic [RAD_BITS/2-1:0] root
);
  import rcm_pkg::*;

  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_BITS-1:0]  steps;
  logic [RAD_BITS-1:0]  rad;
  logic [REM_BITS-1:0]  rem;
  logic [ROOT_BITS-1:0] res;
  logic [REM_BITS+1:0]  cand;
  logic [REM_BITS+1:0]  trial;
  logic [REM_BITS+1:0]  diff;
  logic                 fits;

  // One step: bring down two radicand bits and test 4*root + 1.
  assign cand  = {rem, rad[RAD_BITS-1:RAD_BITS-2]};
  assign trial = (REM_BITS + 2)'({res, 2'b01});
  assign diff  = cand - trial;
  assign fits  = (cand >= trial);

  // Control: one step per root bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_BITS'(ROOT_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the radicand shifts left by two bits a step.
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_BITS-3:0], 2'b00};
      rem <= fits ? diff[REM_BITS-1:0] : cand[REM_BITS-1:0];
      res <= {res[ROOT_BITS-2:0], fits};
    end
  end

  assign root      = res;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/block_rms_current_meter_core.sv
// Block RMS current meter: sum of squares, serial divide, root and gain scaling.
//
// The sample channel takes one signed converter word per accepted transfer
// (sample_valid high, sample_stall low). Each word is squared by a bit-serial
// multiplier and added to the running sum; the sample channel stalls while that
// happens. When the sample count reaches or passes block_length, the sum is
// divided by the count, one quotient bit at a time; its square root is taken,
// one root bit at a time; and the root is scaled by output_gain bit-serially,
// stopping after the last set gain bit. The reading channel holds its word in
// an output register; the next sample is taken while it waits. If reading_stall
// holds the register full when a new reading is ready, the block waits until the
// old word is taken. Reset clears the sum, the count and reading_valid and
// restores the configuration defaults (50 samples, gain 57926). Configuration
// must be written only while no word is in flight; the block itself does not
// enforce this. cfg_ready is always high.
module block_rms_current_meter_core #(
  parameter int SAMPLE_BITS = rcm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  output logic                               reading_valid,
  input  logic                               reading_stall,
  output logic [rcm_pkg::READING_BITS-1:0]   rms_reading,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rcm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rcm_pkg::*;

  localparam int SUM_BITS  = 2 * SAMPLE_BITS + SUM_GUARD_BITS;
  localparam int QUO_BITS  = SUM_BITS + FRAC_BITS;
  localparam int ROOT_BITS = QUO_BITS / 2;
  localparam int PROD_MIN  = SCALE_SHIFT + READING_BITS + 1;
  localparam int PROD_BITS = (ROOT_BITS + GAIN_BITS > PROD_MIN) ?
                             (ROOT_BITS + GAIN_BITS) : PROD_MIN;

  state_t state;
  state_t state_next;

  logic [BLEN_BITS-1:0]     block_length;
  logic [GAIN_BITS-1:0]     output_gain;
  logic [SUM_BITS-1:0]      square_sum;
  logic [BLEN_BITS-1:0]     sample_count;

  logic [SAMPLE_BITS-1:0]   sample_u;
  logic [SAMPLE_BITS-1:0]   mag;
  logic                     accept;
  logic                     end_hit;
  logic                     out_free;

  logic                     sq_start;
  logic                     div_start;
  logic                     root_start;
  logic                     mul_start;
  logic                     clear_block;
  logic                     load_reading;

  unit_stat_t               sq_stat;
  unit_stat_t               div_stat;
  unit_stat_t               root_stat;
  unit_stat_t               mul_stat;

  logic [2*SAMPLE_BITS-1:0] sq_prod;
  logic [QUO_BITS-1:0]      mean;
  logic [ROOT_BITS-1:0]     root;
  logic [PROD_BITS-1:0]     mul_prod;
  logic [READING_BITS-1:0]  scaled;

  // Magnitude of the two's complement sample; the most negative code maps to 2^(N-1).
  assign sample_u = sample;
  assign mag      = sample_u[SAMPLE_BITS-1] ?
                    (~sample_u + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : sample_u;

  assign accept   = sample_valid && !sample_stall;
  assign end_hit  = (sample_count >= block_length);
  assign out_free = !reading_valid || !reading_stall;

  // Configuration registers keep only their low bits.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LENGTH_RESET;
      output_gain  <= OUTPUT_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_LENGTH: block_length <= cfg_data[BLEN_BITS-1:0];
        CFG_OUTPUT_GAIN:  output_gain  <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Running sum of squares and sample count of the current block.
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (clear_block) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else begin
      if (accept) begin
        sample_count <= sample_count + 1'b1;
      end
      if (sq_stat.done) begin
        square_sum <= square_sum + SUM_BITS'(sq_prod);
      end
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (sample_valid) state_next = ST_SQUARE;
      ST_SQUARE:  if (sq_stat.done) state_next = ST_ENDTEST;
      ST_ENDTEST: state_next = end_hit ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE:  if (div_stat.done) state_next = ST_ROOT;
      ST_ROOT:    if (root_stat.done) state_next = ST_SCALE;
      ST_SCALE:   if (mul_stat.done) state_next = ST_WRITE;
      ST_WRITE:   if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sample_stall = 1'b1;
    sq_start     = 1'b0;
    div_start    = 1'b0;
    clear_block  = 1'b0;
    root_start   = 1'b0;
    mul_start    = 1'b0;
    load_reading = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        sq_start     = sample_valid;
      end
      ST_ENDTEST: begin
        div_start   = end_hit;
        clear_block = end_hit;
      end
      ST_DIVIDE: root_start   = div_stat.done;
      ST_ROOT:   mul_start    = root_stat.done;
      ST_WRITE:  load_reading = out_free;
      default: ;
    endcase
  end

  // Squaring of the sample magnitude.
  rcm_serial_mul #(
    .A_BITS (SAMPLE_BITS),
    .B_BITS (SAMPLE_BITS),
    .P_BITS (2 * SAMPLE_BITS)
  ) u_square (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .a       (mag),
    .b       (mag),
    .stat    (sq_stat),
    .product (sq_prod)
  );

  // Mean square in Q16: sum * 2^16 / count.
  rcm_div #(
    .NUM_BITS (QUO_BITS),
    .DEN_BITS (BLEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      ({square_sum, {FRAC_BITS{1'b0}}}),
    .den      (sample_count),
    .stat     (div_stat),
    .quotient (mean)
  );

  // RMS in Q8.
  rcm_sqrt #(
    .RAD_BITS (QUO_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (mean),
    .stat     (root_stat),
    .root     (root)
  );

  // Gain scaling of the root.
  rcm_serial_mul #(
    .A_BITS (ROOT_BITS),
    .B_BITS (GAIN_BITS),
    .P_BITS (PROD_BITS)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (root),
    .b       (output_gain),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  // Drop the fraction and saturate to the reading width.
  assign scaled = (mul_prod[PROD_BITS-1:SCALE_SHIFT+READING_BITS] != '0) ?
                  '1 : mul_prod[SCALE_SHIFT +: READING_BITS];

  // Output register of the reading channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      reading_valid <= 1'b0;
    end else if (load_reading) begin
      reading_valid <= 1'b1;
    end else if (!reading_stall) begin
      reading_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_reading) begin
      rms_reading <= scaled;
    end
  end

`ifndef SYNTHESIS
  // The serial units never run at the same time.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({sq_stat.busy, div_stat.busy, root_stat.busy, mul_stat.busy}))
    else $error("more than one serial unit busy");

  // The block state is cleared as soon as a closing word enters the divider.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (square_sum == '0 && sample_count == '0))
    else $error("sum or count not cleared at block end");

  // The divider and the scaler finish only while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIVIDE))
    else $error("divider finished outside its state");

  assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_SCALE))
    else $error("scaler finished outside its state");

  // A new reading appears only from the write step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(reading_valid) |-> ($past(state) == ST_WRITE))
    else $error("reading raised outside the write step");
`endif

endmodule

FILE: tb/block_rms_current_meter_core_tb.sv
// Self-checking testbench for the block RMS current meter core.
module block_rms_current_meter_core_tb;
  import rcm_pkg::*;

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int SUM_W = 2 * SAMPLE_W + SUM_GUARD_BITS;
  // Drain time that gives the core ample room to settle after a closing word.
  localparam int DRAIN_CYCLES = 200;
  localparam longint unsigned RUN_LIMIT = 64'd40_000_000;
  localparam int N_DIRECTED = 30;

  // One row of the directed stimulus: a register write or a sample word.
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;
  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    logic                      has_lit;
    logic [READING_BITS-1:0]   lit;
  } stim_row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        sample_valid = 1'b0;
  logic                        sample_stall;
  logic signed [SAMPLE_W-1:0]  sample = '0;
  logic                        reading_valid;
  logic                        reading_stall = 1'b0;
  logic [READING_BITS-1:0]     rms_reading;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_data = '0;

  // Mirror of the core: registers, running sum and count.
  logic [BLEN_BITS-1:0]        cur_block_length = BLOCK_LENGTH_RESET;
  logic [GAIN_BITS-1:0]        cur_gain = OUTPUT_GAIN_RESET;
  logic [SUM_W-1:0]            acc_sum = '0;
  logic [BLEN_BITS-1:0]        acc_count = '0;

  logic [READING_BITS-1:0]     pending_readings [$];
  logic [READING_BITS-1:0]     expected_reading;
  int unsigned                 mismatches = 0;
  int unsigned                 send_idle_pct = 17;
  int unsigned                 recv_stall_pct = 68;

  // Signs, extremes, gain limits, zero length, rounding and a mid-block length drop.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_CFG,  CFG_BLOCK_LENGTH, 32'hFFFF_FF01, 1'b0, 16'd0},
    '{ROW_CFG,  CFG_OUTPUT_GAIN,  32'h5A5A_E246, 1'b0, 16'd0},
    '{ROW_WORD, '0,               32'h0000_0000, 1'b1, 16'd0},
    '{ROW_WORD, '0,               32'h0000_7FFF, 1'b1, 16'd28962},
    '{ROW_WORD, '0,               32'h0000_8000, 1'b1, 16'd28963},
    '{ROW_WORD, '0,               32'h0000_FFFF, 1'b1, 16'd0},
    '{ROW_CFG,  CFG_OUTPUT_GAIN,  32'hFFFF_FFFF, 1'b0, 16'd0},
    '{ROW_WORD, '0,               32'h0000_8000, 1'b1, 16'd65535},
    '{ROW_WORD, '0,               32'h0000_7FFF, 1'b0, 16'd0},
    '{ROW_CFG,  CFG_OUTPUT_GAIN,  32'h0000_0000, 1'b0, 16'd0},
    '{ROW_WORD, '0,               32'h0000_7FFF, 1'b1, 16'd0},
    '{ROW_CFG,  CFG_OUTPUT_GAIN,  32'h0001_0000, 1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd1000,      1'b1, 16'd1000},
    '{ROW_WORD, '0,               32'h0000_FC18, 1'b1, 16'd1000},
    '{ROW_CFG,  CFG_BLOCK_LENGTH, 32'hABCD_1200, 1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd300,       1'b1, 16'd300},
    '{ROW_WORD, '0,               32'h0000_5555, 1'b1, 16'd21845},
    '{ROW_WORD, '0,               32'h0000_AAAA, 1'b1, 16'd21846},
    '{ROW_CFG,  CFG_BLOCK_LENGTH, 32'd3,         1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd5,         1'b0, 16'd0},
    '{ROW_WORD, '0,               32'h0000_FFFB, 1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd5,         1'b1, 16'd5},
    '{ROW_CFG,  CFG_BLOCK_LENGTH, 32'd4,         1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd100,       1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd200,       1'b0, 16'd0},
    '{ROW_CFG,  CFG_BLOCK_LENGTH, 32'd1,         1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd300,       1'b0, 16'd0},
    '{ROW_CFG,  CFG_BLOCK_LENGTH, 32'd2,         1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd1,         1'b0, 16'd0},
    '{ROW_WORD, '0,               32'd2,         1'b0, 16'd0}
  };

  block_rms_current_meter_core #(
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .reading_valid (reading_valid),
    .reading_stall (reading_stall),
    .rms_reading   (rms_reading),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Floor square root, built up one bit at a time from the top.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 30; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Adds one sample to the block; returns 1 with the scaled RMS when the block closes.
  function automatic bit meter_accumulate(input logic signed [SAMPLE_W-1:0] s,
                                          output logic [READING_BITS-1:0] reading);
    logic [SAMPLE_W:0]    mag;
    logic [63:0]          square;
    logic [63:0]          mean;
    logic [63:0]          product;
    logic [BLEN_BITS-1:0] divisor;
    reading = '0;
    mag = (SAMPLE_W + 1)'(s[SAMPLE_W-1] ? -longint'(s) : longint'(s));
    square = 64'(mag) * 64'(mag);
    acc_sum = acc_sum + SUM_W'(square);
    acc_count = acc_count + 1'b1;
    if (acc_count < cur_block_length) begin
      return 1'b0;
    end
    divisor = (acc_count == '0) ? BLEN_BITS'(1) : acc_count;
    mean = (64'(acc_sum) << FRAC_BITS) / 64'(divisor);
    product = (64'(floor_sqrt(mean)) * 64'(cur_gain)) >> SCALE_SHIFT;
    reading = (product > 64'hFFFF) ? '1 : product[READING_BITS-1:0];
    acc_sum = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  // Writes a register once the core has delivered everything and gone quiet.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    sample_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_BLOCK_LENGTH) begin
      cur_block_length = data[BLEN_BITS-1:0];
    end else if (index == CFG_OUTPUT_GAIN) begin
      cur_gain = data[GAIN_BITS-1:0];
    end
  endtask

  // Offers one sample word after random idle cycles and waits for it to be taken.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, output bit closed,
                           output logic [READING_BITS-1:0] reading);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      sample <= SAMPLE_W'($urandom);
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    closed = meter_accumulate(s, reading);
  endtask

  // Reading checker and random stall on the reading channel.
  always @(posedge clk) begin
    if (!rst && reading_valid && !reading_stall) begin
      if (pending_readings.size() == 0) begin
        $error("rms_reading: no word expected, got %0d", rms_reading);
        mismatches++;
      end else begin
        expected_reading = pending_readings.pop_front();
        if (rms_reading !== expected_reading) begin
          $error("rms_reading: expected %0d, got %0d", expected_reading, rms_reading);
          mismatches++;
        end
      end
    end
    reading_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    logic signed [SAMPLE_W-1:0] s;
    logic [READING_BITS-1:0]    reading;
    logic [BLEN_BITS-1:0]       blen;
    logic [GAIN_BITS-1:0]       gain;
    logic [CFG_DATA_BITS-1:0]   cfg_word;
    bit                         closed;
    int                         n_items;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; typed-in readings replace the predicted ones.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_register(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i].data[SAMPLE_W-1:0], closed, reading);
        if (closed) begin
          pending_readings.push_back(directed_rows[i].has_lit ? directed_rows[i].lit : reading);
        end
      end
    end

    // Random blocks under three idling patterns, each with fresh register settings.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 68 : 0;
      recv_stall_pct = (mode == 0) ? 68 : (mode == 1) ? 17 : 0;
      for (int phase = 0; phase < 5; phase++) begin
        if (mode == 2 && phase == 0) begin
          blen = 8'd255;
        end else if (phase == 1) begin
          blen = (mode == 1) ? 8'd0 : 8'd1;
        end else if ($urandom_range(3) == 0) begin
          blen = BLEN_BITS'($urandom_range(60, 9));
        end else begin
          blen = BLEN_BITS'($urandom_range(8, 1));
        end
        if (phase == 2) begin
          gain = (mode == 1) ? '0 : '1;
        end else begin
          gain = GAIN_BITS'($urandom_range(131071));
        end
        n_items = (blen == 8'd255) ? 255 : 24;

        cfg_word = $urandom;
        cfg_word[BLEN_BITS-1:0] = blen;
        write_register(CFG_BLOCK_LENGTH, cfg_word);
        cfg_word = $urandom;
        cfg_word[GAIN_BITS-1:0] = gain;
        write_register(CFG_OUTPUT_GAIN, cfg_word);

        for (int k = 0; k < n_items; k++) begin
          case ($urandom_range(7))
            0: s = {1'b1, {(SAMPLE_W - 1){1'b0}}};
            1: s = {1'b0, {(SAMPLE_W - 1){1'b1}}};
            2: s = SAMPLE_W'($signed($urandom_range(32)) - 16);
            default: s = SAMPLE_W'($urandom);
          endcase
          send_word(s, closed, reading);
          if (closed) begin
            pending_readings.push_back(reading);
          end
          // Now and then hold the sample channel until every reading is out.
          if ($urandom_range(63) == 0) begin
            sample_valid <= 1'b0;
            @(posedge clk);
            while (pending_readings.size() != 0) @(posedge clk);
          end
        end
      end
    end

    sample_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a core that stops delivering readings.
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: block_rms_current_meter_core.f
hdl/rcm_pkg.sv
hdl/rcm_serial_mul.sv
hdl/rcm_div.sv
hdl/rcm_sqrt.sv
hdl/block_rms_current_meter_core.sv
tb/block_rms_current_meter_core_tb.sv
